FILE: design/lsdmc_pkg.sv
// Shared types, codes and defaults for the limit switch door motor controller.
`default_nettype none

package lsdmc_pkg;

    // Default sizes of the tick timer and of the stored PWM duty
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int PWM_WIDTH_DEF   = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NO_SWITCH_TIMEOUT = 3'd0,
        CFG_RELEASE_TIMEOUT   = 3'd1,
        CFG_MAX_OSCILLATIONS  = 3'd2,
        CFG_OPENING_SPEED     = 3'd3,
        CFG_CLOSING_SPEED     = 3'd4,
        CFG_SAVED_MOTOR_DIR   = 3'd5
    } t_cfg_idx;

    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] RST_NO_SWITCH_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_RELEASE_TIMEOUT   = 16'd1000;
    localparam logic [7:0]  RST_MAX_OSCILLATIONS  = 8'd3;
    localparam logic [7:0]  RST_OPENING_SPEED     = 8'd200;
    localparam logic [7:0]  RST_CLOSING_SPEED     = 8'd150;
    localparam logic        RST_SAVED_MOTOR_DIR   = 1'b1;

    // Retry counter saturation point
    localparam logic [7:0] RETRY_MAX = 8'd255;

    // Opcodes
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    // Startup modes
    localparam logic [1:0] MODE_AUTO_OPEN = 2'd0;

    // Door states
    typedef enum logic [2:0] {
        DM_CLOSED  = 3'd0,
        DM_OPENING = 3'd1,
        DM_OPEN    = 3'd2,
        DM_CLOSING = 3'd3,
        DM_NOREC   = 3'd4
    } t_door_mode;

    // Status codes
    typedef enum logic [3:0] {
        ST_NONE          = 4'd0,
        ST_CLOSED        = 4'd1,
        ST_OPENED        = 4'd2,
        ST_OPEN_TIMEOUT  = 4'd3,
        ST_CLOSE_TIMEOUT = 4'd4,
        ST_NO_RELEASE    = 4'd5,
        ST_MISSED_CLOSE  = 4'd6,
        ST_BUMPER        = 4'd7,
        ST_UNRECOVERABLE = 4'd8
    } t_status;

    // Input word
    typedef struct packed {
        logic       opcode;
        logic       switch_upper;
        logic       switch_lower;
        logic       switch_bumper;
        logic       cmd_open;
        logic       cmd_close;
        logic [1:0] startup_mode;
    } t_door_in;

    // Result word
    typedef struct packed {
        logic [2:0] door_state;
        logic [3:0] status_code;
        logic       pin_one_level;
        logic       pin_two_level;
        logic [7:0] pwm_duty;
        logic       motor_direction;
    } t_door_out;

    // Configuration write word
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

FILE: design/lsdmc_if.sv
// Valid/ready channel interfaces for input, result and configuration words.
`default_nettype none

interface lsdmc_in_if;
    import lsdmc_pkg::*;
    logic     valid;
    logic     ready;
    t_door_in word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface lsdmc_out_if;
    import lsdmc_pkg::*;
    logic      valid;
    logic      ready;
    t_door_out word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface lsdmc_cfg_if;
    import lsdmc_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: design/limit_switch_door_motor_controller.sv
// Top level: door state machine with tick timer, retry counter and motor outputs.
//
//   channel  | dir | word        | accepted when
//   ---------+-----+-------------+------------------------------
//   i_cmd    | in  | t_door_in   | i_cmd.valid && i_cmd.ready
//   o_res    | out | t_door_out  | o_res.valid && o_res.ready
//   i_cfg    | in  | t_cfg_wr    | i_cfg.valid && i_cfg.ready
//
// One word per cycle sustained while results are taken. An accepted input word
// goes to the input register, then the state update writes its result register.
// The state loop (door mode, timer, retry count) is computed combinationally from the registered state.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the input register; a new word is still taken while
// the result register drains in the same cycle. Config writes are always ready.
`default_nettype none

module limit_switch_door_motor_controller #(
    parameter int TIMER_WIDTH = lsdmc_pkg::TIMER_WIDTH_DEF,
    parameter int PWM_WIDTH   = lsdmc_pkg::PWM_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lsdmc_in_if.sink    i_cmd,
    lsdmc_out_if.source o_res,
    lsdmc_cfg_if.sink   i_cfg
);
    import lsdmc_pkg::*;

    // configuration registers
    logic [15:0] r_no_switch_to;
    logic [15:0] r_release_to;
    logic [7:0]  r_max_osc;
    logic [7:0]  r_open_speed;
    logic [7:0]  r_close_speed;
    logic        r_saved_dir;

    // pipeline registers
    logic      r_in_valid;
    t_door_in  r_in;
    logic      r_out_valid;
    t_door_out r_out;

    // controller state
    t_door_mode             r_mode, n_mode;
    logic                   r_entry, n_entry;
    logic                   r_released, n_released;
    logic [7:0]             r_retry, n_retry;
    logic                   r_dir, n_dir;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic                   r_tmr_run, n_tmr_run;
    logic                   r_tmo_pend, n_tmo_pend;
    logic [1:0]             r_pins, n_pins;
    logic [PWM_WIDTH-1:0]   r_pwm, n_pwm;
    t_status                status;
    t_door_out              n_out;

    logic advance;

    // timer periods sized to the timer width
    logic [TIMER_WIDTH+15:0] no_switch_ext, release_ext;
    logic [TIMER_WIDTH-1:0]  no_switch_per, release_per;

    assign no_switch_ext = {{TIMER_WIDTH{1'b0}}, r_no_switch_to};
    assign release_ext   = {{TIMER_WIDTH{1'b0}}, r_release_to};
    assign no_switch_per = no_switch_ext[TIMER_WIDTH-1:0];
    assign release_per   = release_ext[TIMER_WIDTH-1:0];

    // handshakes
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.word  = r_out;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_switch_to <= RST_NO_SWITCH_TIMEOUT;
            r_release_to   <= RST_RELEASE_TIMEOUT;
            r_max_osc      <= RST_MAX_OSCILLATIONS;
            r_open_speed   <= RST_OPENING_SPEED;
            r_close_speed  <= RST_CLOSING_SPEED;
            r_saved_dir    <= RST_SAVED_MOTOR_DIR;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.word.index))
                CFG_NO_SWITCH_TIMEOUT: r_no_switch_to <= i_cfg.word.data;
                CFG_RELEASE_TIMEOUT:   r_release_to   <= i_cfg.word.data;
                CFG_MAX_OSCILLATIONS:  r_max_osc      <= i_cfg.word.data[7:0];
                CFG_OPENING_SPEED:     r_open_speed   <= i_cfg.word.data[7:0];
                CFG_CLOSING_SPEED:     r_close_speed  <= i_cfg.word.data[7:0];
                CFG_SAVED_MOTOR_DIR:   r_saved_dir    <= i_cfg.word.data[0];
                default: ;
            endcase
        end
    end

    // next state for one word
    always_comb begin
        logic moved;
        moved      = 1'b0;
        status     = ST_NONE;
        n_mode     = r_mode;
        n_entry    = r_entry;
        n_released = r_released;
        n_retry    = r_retry;
        n_dir      = r_dir;
        n_timer    = r_timer;
        n_tmr_run  = r_tmr_run;
        n_tmo_pend = r_tmo_pend;
        n_pins     = r_pins;
        n_pwm      = r_pwm;

        if (t_opcode'(r_in.opcode) == OP_START) begin
            // start: reload direction, pick state from switches and mode
            n_dir   = r_saved_dir;
            n_entry = 1'b1;
            if (r_in.switch_upper) begin
                n_mode = DM_OPEN;
            end else if (r_in.switch_lower) begin
                n_mode = DM_CLOSED;
            end else begin
                n_mode  = (r_in.startup_mode == MODE_AUTO_OPEN) ? DM_OPENING : DM_CLOSING;
                n_retry = '0;
            end
        end else begin
            // one-shot timer countdown
            if (r_tmr_run) begin
                if (r_timer <= TIMER_WIDTH'(1)) begin
                    n_timer    = '0;
                    n_tmr_run  = 1'b0;
                    n_tmo_pend = 1'b1;
                end else begin
                    n_timer = r_timer - TIMER_WIDTH'(1);
                end
            end

            unique case (r_mode)
                DM_CLOSED: begin
                    if (r_entry) begin
                        n_retry = '0;
                        n_pwm   = '0;
                        status  = ST_CLOSED;
                        n_entry = 1'b0;
                    end
                    if (r_in.cmd_open) begin
                        n_mode = DM_OPENING; n_entry = 1'b1; moved = 1'b1;
                    end
                end
                DM_OPENING: begin
                    if (r_entry) begin
                        n_pins    = {!r_dir, r_dir};
                        n_pwm     = PWM_WIDTH'(r_open_speed);
                        n_timer   = no_switch_per;
                        n_tmr_run = 1'b1;
                        n_entry   = 1'b0;
                    end
                    if (r_in.switch_upper) begin
                        n_mode = DM_OPEN; n_entry = 1'b1; moved = 1'b1;
                    end else if (r_in.cmd_close) begin
                        n_mode = DM_CLOSING; n_entry = 1'b1; moved = 1'b1;
                    end else if (n_tmo_pend) begin
                        n_tmo_pend = 1'b0;
                        status     = ST_OPEN_TIMEOUT;
                        if (n_retry != RETRY_MAX) n_retry = n_retry + 8'd1;
                        n_mode  = (n_retry > r_max_osc) ? DM_NOREC : DM_CLOSING;
                        n_entry = 1'b1;
                        moved   = 1'b1;
                    end
                    if (moved) n_tmr_run = 1'b0;
                end
                DM_OPEN: begin
                    if (r_entry) begin
                        n_retry = '0;
                        n_pins  = 2'b00;
                        n_pwm   = PWM_WIDTH'(r_open_speed);
                        status  = ST_OPENED;
                        n_entry = 1'b0;
                    end
                    if (r_in.cmd_close) begin
                        n_mode = DM_CLOSING; n_entry = 1'b1; moved = 1'b1;
                    end
                end
                DM_CLOSING: begin
                    if (r_entry) begin
                        n_pins     = {r_dir, !r_dir};
                        n_pwm      = PWM_WIDTH'(r_close_speed);
                        n_timer    = release_per;
                        n_tmr_run  = 1'b1;
                        n_released = 1'b0;
                        n_entry    = 1'b0;
                    end
                    if (r_in.switch_lower) begin
                        n_mode = DM_CLOSED; n_entry = 1'b1; moved = 1'b1;
                    end else if (!n_released && !r_in.switch_upper) begin
                        // upper switch let go: now wait for the lower one
                        n_released = 1'b1;
                        n_timer    = no_switch_per;
                        n_tmr_run  = 1'b1;
                    end else if (n_tmo_pend) begin
                        n_tmo_pend = 1'b0;
                        if (n_released) begin
                            status = ST_CLOSE_TIMEOUT;
                        end else begin
                            status = ST_NO_RELEASE;
                            n_dir  = !r_dir;
                        end
                        if (n_retry != RETRY_MAX) n_retry = n_retry + 8'd1;
                        if (n_retry > r_max_osc) n_mode = DM_NOREC;
                        else n_mode = n_released ? DM_OPENING : DM_CLOSING;
                        n_entry = 1'b1;
                        moved   = 1'b1;
                    end else if (n_released && r_in.switch_upper) begin
                        // door went up instead of down: swap direction
                        status = ST_MISSED_CLOSE;
                        n_dir  = !r_dir;
                        if (n_retry != RETRY_MAX) n_retry = n_retry + 8'd1;
                        n_mode  = (n_retry > r_max_osc) ? DM_NOREC : DM_CLOSING;
                        n_entry = 1'b1;
                        moved   = 1'b1;
                    end else if (r_in.cmd_open) begin
                        n_mode = DM_OPENING; n_entry = 1'b1; moved = 1'b1;
                    end else if (r_in.switch_bumper) begin
                        status = ST_BUMPER;
                        n_mode = DM_OPENING; n_entry = 1'b1; moved = 1'b1;
                    end
                    if (moved) n_tmr_run = 1'b0;
                end
                DM_NOREC: begin
                    if (r_entry) begin
                        n_pwm  = '0;
                        status = ST_UNRECOVERABLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word
    always_comb begin
        n_out.door_state      = n_mode;
        n_out.status_code     = status;
        n_out.pin_one_level   = n_pins[0];
        n_out.pin_two_level   = n_pins[1];
        n_out.pwm_duty        = n_pwm[7:0];
        n_out.motor_direction = n_dir;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) r_in <= i_cmd.word;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) r_out <= n_out;
    end

    // controller state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= DM_CLOSED;
            r_entry    <= 1'b0;
            r_released <= 1'b0;
            r_retry    <= '0;
            r_dir      <= RST_SAVED_MOTOR_DIR;
            r_timer    <= '0;
            r_tmr_run  <= 1'b0;
            r_tmo_pend <= 1'b0;
            r_pins     <= 2'b00;
            r_pwm      <= '0;
        end else if (advance) begin
            r_mode     <= n_mode;
            r_entry    <= n_entry;
            r_released <= n_released;
            r_retry    <= n_retry;
            r_dir      <= n_dir;
            r_timer    <= n_timer;
            r_tmr_run  <= n_tmr_run;
            r_tmo_pend <= n_tmo_pend;
            r_pins     <= n_pins;
            r_pwm      <= n_pwm;
        end
    end

    // checks
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after a word was processed");

    a_unrec_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status_code == ST_UNRECOVERABLE)
            |-> r_out.door_state == DM_NOREC)
        else $error("unrecoverable status outside the unrecoverable state");

    a_opened_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status_code == ST_OPENED)
            |-> (!r_out.pin_one_level && !r_out.pin_two_level))
        else $error("motor pins driven while reporting opened");

endmodule

`default_nettype wire
